>>> rtl/oed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package oed_pkg;

    // parameters per instruction are capped here
    localparam int unsigned MAX_PARAMS = 4;

    // result queue
    localparam int unsigned QDEPTH = 8;
    localparam int unsigned QAW    = 3;
    localparam int unsigned QCW    = 4;
    // one request gives at most this many results
    localparam int unsigned MAX_RES = 3;

    // parameter kinds as reported
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_REG  = 3'd1;
    localparam logic [2:0] KIND_DIR2 = 3'd2;
    localparam logic [2:0] KIND_IND  = 3'd3;
    localparam logic [2:0] KIND_DIR4 = 3'd4;

    // 2-bit fields of the encoding byte
    localparam logic [1:0] FLD_NONE = 2'd0;
    localparam logic [1:0] FLD_DIR  = 2'd2;

    typedef struct packed {
        logic       starts_instruction;
        logic [7:0] byte_value;
        logic       has_encoding;
        logic [2:0] param_count;
        logic       long_direct;
        logic [2:0] fixed_kind;
        logic       opcode_valid;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  slot;
        logic [2:0]  kind;
        logic [31:0] param_value;
        logic [2:0]  used_count;
        logic [4:0]  instr_length;
        logic        has_param;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     res;
    } t_bundle;

    // bytes taken by a parameter of the given kind
    function automatic logic [2:0] kind_size(input logic [2:0] kind);
        logic [2:0] size;
        case (kind)
            KIND_NONE: size = 3'd0;
            KIND_REG:  size = 3'd1;
            KIND_DIR4: size = 3'd4;
            default:   size = 3'd2;
        endcase
        return size;
    endfunction

    function automatic t_result mk_result(input logic [1:0] slot, input logic [2:0] kind,
                                          input logic [31:0] value, input logic has_param);
        t_result r;
        r              = '0;
        r.slot         = slot;
        r.kind         = kind;
        r.param_value  = value;
        r.has_param    = has_param;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/oed_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface oed_in_if;
    import oed_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface oed_out_if;
    import oed_pkg::*;
    logic    valid;
    logic    ready;
    t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/oed_decode_core.sv
`timescale 1ns / 1ps
`default_nettype none

module oed_decode_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  oed_pkg::t_in_item i_item,
    output oed_pkg::t_bundle  o_bundle
);
    import oed_pkg::*;

    logic        r_busy,  n_busy;
    logic [7:0]  r_rem,   n_rem;
    logic [2:0]  r_slot,  n_slot;
    logic [2:0]  r_kind,  n_kind;
    logic [2:0]  r_left,  n_left;
    logic [31:0] r_acc,   n_acc;
    logic [4:0]  r_cons,  n_cons;
    logic [2:0]  r_lim,   n_lim;
    logic        r_long,  n_long;

    logic        feed_req;
    logic        adv_req;
    logic        fin_req;
    logic [2:0]  size;
    logic [1:0]  field;
    logic [2:0]  kind;
    logic [1:0]  cnt;
    t_bundle     bundle;

    always_comb begin
        n_busy   = r_busy;
        n_rem    = r_rem;
        n_slot   = r_slot;
        n_kind   = r_kind;
        n_left   = r_left;
        n_acc    = r_acc;
        n_cons   = r_cons;
        n_lim    = r_lim;
        n_long   = r_long;
        feed_req = 1'b0;
        adv_req  = 1'b0;
        fin_req  = 1'b0;
        size     = 3'd0;
        field    = FLD_NONE;
        kind     = KIND_NONE;
        cnt      = 2'd0;
        bundle   = '0;

        if (i_accept) begin
            if (i_item.starts_instruction) begin
                n_busy = 1'b0;
                n_slot = 3'd0;
                n_kind = KIND_NONE;
                n_left = 3'd0;
                n_acc  = '0;
                n_long = i_item.long_direct;
                if (i_item.has_encoding) begin
                    n_rem   = i_item.byte_value;
                    n_lim   = (i_item.param_count > 3'(MAX_PARAMS)) ?
                              3'(MAX_PARAMS) : i_item.param_count;
                    n_cons  = 5'd2;
                    adv_req = 1'b1;
                end else begin
                    n_rem  = 8'd0;
                    n_cons = 5'd1;
                    if (i_item.opcode_valid) begin
                        n_lim  = 3'd1;
                        n_slot = 3'd1;
                        size   = kind_size(i_item.fixed_kind);
                        if (size == 3'd0) begin
                            bundle.res[cnt] = mk_result(2'd0, KIND_NONE, 32'd0, 1'b1);
                            cnt             = cnt + 2'd1;
                            fin_req         = 1'b1;
                        end else begin
                            n_busy   = 1'b1;
                            n_kind   = i_item.fixed_kind;
                            n_left   = size;
                            feed_req = 1'b1;
                        end
                    end else begin
                        n_lim   = 3'd0;
                        fin_req = 1'b1;
                    end
                end
            end else if (r_busy) begin
                feed_req = 1'b1;
            end
        end

        // one parameter byte, big-endian
        if (feed_req) begin
            n_acc  = {n_acc[23:0], i_item.byte_value};
            n_cons = n_cons + 5'd1;
            n_left = n_left - 3'd1;
            if (n_left == 3'd0) begin
                bundle.res[cnt] = mk_result(2'(n_slot - 3'd1), n_kind, n_acc, 1'b1);
                cnt             = cnt + 2'd1;
                n_busy          = 1'b0;
                adv_req         = 1'b1;
            end
        end

        // walk the encoding fields until a parameter needs bytes or decoding ends
        if (adv_req) begin
            for (int it = 0; it < 5; it++) begin
                if (!n_busy && !fin_req) begin
                    if (n_rem == 8'd0 || n_slot >= n_lim || n_slot >= 3'd4) begin
                        fin_req = 1'b1;
                    end else begin
                        case (n_slot[1:0])
                            2'd0: begin
                                field      = n_rem[7:6];
                                n_rem[7:6] = 2'd0;
                            end
                            2'd1: begin
                                field      = n_rem[5:4];
                                n_rem[5:4] = 2'd0;
                            end
                            2'd2: begin
                                field      = n_rem[3:2];
                                n_rem[3:2] = 2'd0;
                            end
                            default: begin
                                field      = n_rem[1:0];
                                n_rem[1:0] = 2'd0;
                            end
                        endcase
                        kind   = (field == FLD_DIR && n_long) ? KIND_DIR4 : {1'b0, field};
                        n_slot = n_slot + 3'd1;
                        size   = kind_size(kind);
                        if (size == 3'd0) begin
                            if (cnt < 2'(MAX_RES)) begin
                                bundle.res[cnt] = mk_result(2'(n_slot - 3'd1), KIND_NONE,
                                                            32'd0, 1'b1);
                                cnt             = cnt + 2'd1;
                            end
                        end else begin
                            n_busy = 1'b1;
                            n_kind = kind;
                            n_left = size;
                            n_acc  = '0;
                        end
                    end
                end
            end
        end

        // mark the final result; an empty instruction still reports once
        if (fin_req) begin
            if (cnt == 2'd0) begin
                bundle.res[cnt] = mk_result(2'd0, KIND_NONE, 32'd0, 1'b0);
                cnt             = 2'd1;
            end
            bundle.res[2'(cnt - 2'd1)].used_count   = n_slot;
            bundle.res[2'(cnt - 2'd1)].instr_length = n_cons;
            bundle.res[2'(cnt - 2'd1)].last         = 1'b1;
            n_busy = 1'b0;
        end

        bundle.count = cnt;
    end

    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rem  <= '0;
            r_slot <= '0;
            r_kind <= '0;
            r_left <= '0;
            r_acc  <= '0;
            r_cons <= '0;
            r_lim  <= '0;
            r_long <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_rem  <= n_rem;
            r_slot <= n_slot;
            r_kind <= n_kind;
            r_left <= n_left;
            r_acc  <= n_acc;
            r_cons <= n_cons;
            r_lim  <= n_lim;
            r_long <= n_long;
        end
    end

    a_busy_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_left != 3'd0)
        else $error("decoder busy with no bytes left");

    a_last_ends_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && bundle.count != 2'd0 && bundle.res[2'(bundle.count - 2'd1)].last)
        |=> !r_busy)
        else $error("decoder still busy after final result");

    a_empty_instr_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.starts_instruction && !i_item.has_encoding
         && !i_item.opcode_valid) |-> bundle.count == 2'd1)
        else $error("instruction without parameters must give exactly one result");

endmodule

`default_nettype wire

>>> rtl/oed_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module oed_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  oed_pkg::t_bundle i_push,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output oed_pkg::t_result o_data
);
    import oed_pkg::*;

    t_result        r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_count;
    logic [QCW-1:0] n_count;
    logic           pop;

    // room for a full bundle must be there before a request is taken
    assign o_space = r_count <= QCW'(QDEPTH - MAX_RES);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign n_count = r_count + QCW'(i_push.count) - QCW'(pop);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) < i_push.count) begin
                r_mem[QAW'(r_wr + QAW'(i))] <= i_push.res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QAW'(i_push.count);
            r_rd    <= r_rd + QAW'(pop);
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_space)
        else $error("results pushed without room");

    a_push_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |=> o_valid)
        else $error("pushed result not visible");

endmodule

`default_nettype wire

>>> rtl/operand_encoding_decoder.sv
// Operand decoder for a byte-coded instruction stream.
// Input channel i_in: one instruction byte per request. The first byte after
// the opcode comes with starts_instruction set and the opcode descriptor
// (has_encoding, param_count, long_direct, fixed_kind, opcode_valid).
// Output channel o_out: one result per parameter in slot order; the last
// result of an instruction has last set and carries used_count and
// instr_length. An instruction with no parameters gives one result with
// has_param clear.
// Results of a taken byte leave o_out through an 8-entry result queue. One
// byte is taken per cycle while i_in.ready is high. A byte may complete up
// to three results; these leave through the output port at one per cycle
// while o_out.ready is high, which sets the sustained rate when many
// none-fields are packed together. i_in.ready stays high while at least
// three entries are free, so a stalled receiver stops intake only once
// fewer than three are free. Bytes that arrive with no decode under way are
// dropped. A new starts_instruction byte abandons any unfinished
// instruction. Reset clears the decode state and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module operand_encoding_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oed_in_if.sink    i_in,
    oed_out_if.source o_out
);
    import oed_pkg::*;

    logic    space;
    logic    accept;
    t_bundle bundle;

    assign i_in.ready = space;
    assign accept     = i_in.valid && space;

    oed_decode_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in.payload),
        .o_bundle (bundle)
    );

    oed_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bundle),
        .o_space (space),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (o_out.payload)
    );

endmodule

`default_nettype wire
